// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/bcc_pkg.sv
// Types and constants shared by the button click classifier modules.
package bcc_pkg;

   localparam int TICK_W  = 16;
   localparam int PHASE_W = 3;
   localparam int EVENT_W = 3;

   localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

   // Button phase codes
   localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
   localparam logic [PHASE_W-1:0] PH_DEB1  = 3'd1;
   localparam logic [PHASE_W-1:0] PH_HELD  = 3'd2;
   localparam logic [PHASE_W-1:0] PH_REL   = 3'd3;
   localparam logic [PHASE_W-1:0] PH_DEB2  = 3'd4;
   localparam logic [PHASE_W-1:0] PH_WAITD = 3'd5;
   localparam logic [PHASE_W-1:0] PH_WAITL = 3'd6;

   // Event codes
   localparam logic [EVENT_W-1:0] EV_NONE    = 3'd0;
   localparam logic [EVENT_W-1:0] EV_SINGLE  = 3'd1;
   localparam logic [EVENT_W-1:0] EV_DOUBLE  = 3'd2;
   localparam logic [EVENT_W-1:0] EV_LONG    = 3'd3;
   localparam logic [EVENT_W-1:0] EV_LONGREL = 3'd4;

   // Command codes
   localparam logic CMD_SCAN = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // Register indexes
   localparam logic REG_LONG_PRESS = 1'b0;
   localparam logic REG_CLICK_GAP  = 1'b1;

   typedef struct packed {
      logic [TICK_W-1:0] long_press_ticks;
      logic [TICK_W-1:0] click_gap_ticks;
   } bcc_cfg_type;

   typedef struct packed {
      logic scan_en;
      logic clear_en;
      logic pressed;
   } bcc_cell_ctl_type;

endpackage

// File: rtl/bcc_cell.sv
// Per-button phase machine, tick counter and latched event.
module bcc_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  bcc_pkg::bcc_cell_ctl_type        cell_ctl,
   input  bcc_pkg::bcc_cfg_type             cfg,
   output logic [bcc_pkg::EVENT_W-1:0]      event_code
);

   logic [bcc_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [bcc_pkg::TICK_W-1:0]  count_ff, count_in;
   logic [bcc_pkg::EVENT_W-1:0] event_ff, event_in;
   logic [bcc_pkg::TICK_W-1:0]  count_bump;

   assign count_bump = (count_ff != bcc_pkg::TICK_MAX) ?
                       count_ff + bcc_pkg::TICK_W'(1) : count_ff;

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      event_in = event_ff;
      if (cell_ctl.clear_en) begin
         event_in = bcc_pkg::EV_NONE;
      end
      if (cell_ctl.scan_en) begin
         case (phase_ff)
            bcc_pkg::PH_DEB1: begin
               if (cell_ctl.pressed) begin
                  phase_in = bcc_pkg::PH_HELD;
                  count_in = '0;
               end else begin
                  phase_in = bcc_pkg::PH_IDLE;
               end
            end
            bcc_pkg::PH_HELD: begin
               if (!cell_ctl.pressed) begin
                  phase_in = bcc_pkg::PH_REL;
                  count_in = '0;
               end else if (count_ff > cfg.long_press_ticks) begin
                  event_in = bcc_pkg::EV_LONG;
                  phase_in = bcc_pkg::PH_WAITL;
               end else begin
                  count_in = count_bump;
               end
            end
            bcc_pkg::PH_REL: begin
               if (cell_ctl.pressed) begin
                  phase_in = bcc_pkg::PH_DEB2;
               end else if (count_ff > cfg.click_gap_ticks) begin
                  event_in = bcc_pkg::EV_SINGLE;
                  phase_in = bcc_pkg::PH_IDLE;
               end else begin
                  count_in = count_bump;
               end
            end
            bcc_pkg::PH_DEB2: begin
               if (cell_ctl.pressed) begin
                  event_in = bcc_pkg::EV_DOUBLE;
                  phase_in = bcc_pkg::PH_WAITD;
               end else begin
                  phase_in = bcc_pkg::PH_REL;
               end
            end
            bcc_pkg::PH_WAITD: begin
               if (!cell_ctl.pressed) begin
                  phase_in = bcc_pkg::PH_IDLE;
               end
            end
            bcc_pkg::PH_WAITL: begin
               if (!cell_ctl.pressed) begin
                  event_in = bcc_pkg::EV_LONGREL;
                  phase_in = bcc_pkg::PH_IDLE;
               end
            end
            default: begin
               // idle, and the unused code acts as idle
               if (cell_ctl.pressed) begin
                  phase_in = bcc_pkg::PH_DEB1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= bcc_pkg::PH_IDLE;
         count_ff <= '0;
         event_ff <= bcc_pkg::EV_NONE;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         event_ff <= event_in;
      end
   end

   assign event_code = event_ff;

endmodule

// File: rtl/bcc_rsp_buf.sv
// Two-entry result queue: output register plus skid entry.
module bcc_rsp_buf (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push_valid,
   output logic                        push_ready,
   input  logic [bcc_pkg::EVENT_W-1:0] push_data,
   output logic                        pop_valid,
   input  logic                        pop_ready,
   output logic [bcc_pkg::EVENT_W-1:0] pop_data
);

   logic [1:0]                  count_ff, count_in;
   logic [bcc_pkg::EVENT_W-1:0] head_ff, head_in;
   logic [bcc_pkg::EVENT_W-1:0] tail_ff, tail_in;
   logic                        push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = head_ff;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      case ({push, pop})
         2'b10: begin
            count_in = count_ff + 2'd1;
            if (count_ff == 2'd0) begin
               head_in = push_data;
            end else begin
               tail_in = push_data;
            end
         end
         2'b01: begin
            count_in = count_ff - 2'd1;
            head_in  = tail_ff;
         end
         2'b11: begin
            // only reachable with one entry held
            head_in = push_data;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

// File: rtl/button_click_classifier.sv
// Top level of the button click classifier: csr port, button cells, result queue.
// Each result is registered in the result queue and shows on rsp_valid once the results ahead of it are taken.
// Throughput: one transaction per cycle while the result queue has room (req_ready high).
// A two-entry result queue keeps req_ready high while one result waits.
// Reset (synchronous, active high) returns every button to idle with zero ticks and
// no event, empties the queue and loads thresholds 1000 and 300.
module button_click_classifier #(
   parameter int NUM_BUTTONS = 4
) (
   input  logic        clock,
   input  logic        reset,
   // scan / read transactions
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [1:0]  req_button_index,
   input  logic        req_pin_level,
   // result transactions
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_code,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   bcc_pkg::bcc_cfg_type        cfg_ff, cfg_in;
   logic                        csr_write;
   logic                        req_take;
   logic [NUM_BUTTONS-1:0]      cell_hit;
   logic [bcc_pkg::EVENT_W-1:0] cell_event [NUM_BUTTONS];
   logic [bcc_pkg::EVENT_W-1:0] read_event;
   logic [bcc_pkg::EVENT_W-1:0] item_event;

   // Configuration registers: paddr[2] picks the register.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         if (paddr[2] == bcc_pkg::REG_LONG_PRESS) begin
            cfg_in.long_press_ticks = pwdata[bcc_pkg::TICK_W-1:0];
         end else begin
            cfg_in.click_gap_ticks = pwdata[bcc_pkg::TICK_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_press_ticks <= 16'd1000;
         cfg_ff.click_gap_ticks  <= 16'd300;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign prdata = (paddr[2] == bcc_pkg::REG_LONG_PRESS) ?
                   {16'd0, cfg_ff.long_press_ticks} : {16'd0, cfg_ff.click_gap_ticks};

   // A transaction updates the selected cell at the accept edge; an index with
   // no cell behind it touches nothing and reads as no event.
   assign req_take = req_valid && req_ready;

   for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_cell
      bcc_pkg::bcc_cell_ctl_type cell_ctl;

      assign cell_hit[i]       = (32'(req_button_index) == i);
      assign cell_ctl.scan_en  = req_take && cell_hit[i] && (req_command == bcc_pkg::CMD_SCAN);
      assign cell_ctl.clear_en = req_take && cell_hit[i] && (req_command == bcc_pkg::CMD_READ);
      assign cell_ctl.pressed  = !req_pin_level;

      bcc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_ctl   (cell_ctl),
         .cfg        (cfg_ff),
         .event_code (cell_event[i])
      );
   end

   // Select the latched event of the addressed button.
   always_comb begin
      read_event = bcc_pkg::EV_NONE;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         if (cell_hit[i]) begin
            read_event = read_event | cell_event[i];
         end
      end
   end

   // Scans always report no event; reads return the latched one.
   assign item_event = (req_command == bcc_pkg::CMD_READ) ? read_event : bcc_pkg::EV_NONE;

   // Hold results here until the consumer takes them.
   bcc_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_data  (item_event),
      .pop_valid  (rsp_valid),
      .pop_ready  (rsp_ready),
      .pop_data   (rsp_event_code)
   );

endmodule

// File: rtl/bcc_checker.sv
// Port-level checker for the button click classifier and its bind.
`include "assert_macros.svh"

module bcc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_command,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_event_code
);

   logic rsp_stall;
   logic scan_take;
   logic shows_none;

   assign rsp_stall  = rsp_valid && !rsp_ready;
   // a scan accepted into an empty queue shows up next cycle
   assign scan_take  = req_valid && req_ready && (req_command == bcc_pkg::CMD_SCAN) &&
                       !rsp_valid;
   assign shows_none = rsp_valid && (rsp_event_code == bcc_pkg::EV_NONE);

   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, rsp_stall |=> rsp_valid, "result dropped")
   `ASSERT_CLK_RST(a_scan_none, clock, reset, scan_take |=> shows_none, "scan not no event")
   `ASSERT_CLK_RST(a_code_range, clock, reset, rsp_valid |-> rsp_event_code <= bcc_pkg::EV_LONGREL, "bad code")
   `ASSERT_CLK_RST(a_full_shows, clock, reset, !req_ready |-> rsp_valid, "full, no result")

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (.*);
